### rtl/core/clda_pkg.sv
// ----------------------------------------------------------------------------
// clda_pkg
// Shared widths, word layouts and codes for the code lookup dot accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package clda_pkg;

  // Table store geometry
  localparam int TABLE_AW       = 14;
  localparam int TABLE_DW       = 32;
  localparam int TABLE_DEPTH    = 2 ** TABLE_AW;

  // Code geometry
  localparam int MAX_CODE_BYTES = 64;
  localparam int POS_W          = $clog2(MAX_CODE_BYTES);
  localparam int LEN_W          = 7;
  localparam int BYTE_W         = 8;
  localparam int NIB_W          = 4;

  // Accumulator
  localparam int SUM_W          = 40;
  localparam int PAIR_W         = TABLE_DW + 1;

  // Stream word widths
  localparam int IN_DATA_W      = 56;
  localparam int IN_USER_W      = 1;
  localparam int OUT_DATA_W     = 40;

  // Configuration port
  localparam int CFG_AW         = 1;
  localparam int CFG_DW         = LEN_W;

  // Word kind carried in in_tuser
  typedef enum logic [IN_USER_W-1:0] {
    CMD_TABLE_WRITE = 1'b0,
    CMD_CODE_BYTE   = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_NIBBLE_MODE = 1'b0,
    CFG_CODE_LENGTH = 1'b1
  } cfg_idx_t;

  localparam logic [LEN_W-1:0] CODE_LENGTH_RST = LEN_W'(16);

endpackage

`default_nettype wire

### rtl/core/code_lut_dot_accumulate.sv
// ----------------------------------------------------------------------------
// code_lut_dot_accumulate
// Scores quantized codes against a lookup table held in an on-chip store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream: in_tuser selects the word kind. A table-write word stores
//         one 32-bit signed Q16.16 entry; a code-byte word adds one table
//         entry (byte mode) or two entries (nibble mode) to a running sum.
//   out_* stream: one 40-bit signed sum per code, sent after the byte that
//         completes the configured code length.
//   cfg_* port:   nibble_mode and code_length, written while idle.
// Throughput: one word per cycle unless the pipeline stalls. The table store
//   has one write port and two read ports, so a nibble-mode byte reads both
//   of its entries together. A finished sum passes the table read, pair add
//   and accumulate into the output register before out_tvalid shows it.
// Reset: clears the pipeline, byte position, running sum and output, and
//   sets nibble_mode to 0 and code_length to 16. The table store is not
//   cleared; every entry must be written before a code byte reads it.
// Stall: bytes that do not finish a code keep flowing while a sum waits in
//   the output register. Only a second finished sum stalls the pipeline,
//   which then drops in_tready until out_tready takes the waiting sum.
// ----------------------------------------------------------------------------
`default_nettype none

module code_lut_dot_accumulate
  import clda_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [13:0] table_addr, [45:14] table_word, [53:46] code_byte, [55:54] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] cmd
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [39:0] dot_sum
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // Configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_AW-1:0]     cfg_addr,
  input  wire logic [CFG_DW-1:0]     cfg_wdata
);

  // Unpack input word
  logic [TABLE_AW-1:0] in_table_addr;
  logic [TABLE_DW-1:0] in_table_word;
  logic [BYTE_W-1:0]   in_code_byte;
  cmd_t                in_cmd;

  assign in_table_addr = in_tdata[TABLE_AW-1:0];
  assign in_table_word = in_tdata[TABLE_AW+TABLE_DW-1:TABLE_AW];
  assign in_code_byte  = in_tdata[TABLE_AW+TABLE_DW+BYTE_W-1:TABLE_AW+TABLE_DW];
  assign in_cmd        = cmd_t'(in_tuser);

  // Configuration registers
  logic             nibble_mode_r;
  logic [LEN_W-1:0] code_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nibble_mode_r <= 1'b0;
      code_length_r <= CODE_LENGTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_NIBBLE_MODE: nibble_mode_r <= cfg_wdata[0];
        CFG_CODE_LENGTH: code_length_r <= cfg_wdata[LEN_W-1:0];
        default:         ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid_r, s1_last_r, s1_nib_r;
  logic s2_valid_r, s2_last_r;
  logic out_valid_r;
  logic en;
  logic acc_in, acc_code, acc_write;

  assign en        = !(s2_valid_r && s2_last_r && out_valid_r && !out_tready);
  assign in_tready = en;
  assign acc_in    = in_tvalid && en;
  assign acc_code  = acc_in && (in_cmd == CMD_CODE_BYTE);
  assign acc_write = acc_in && (in_cmd == CMD_TABLE_WRITE);

  // Byte position and end-of-code detect
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] eff_len, pos_inc;
  logic             last_byte;

  always_comb begin
    if (code_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (code_length_r > LEN_W'(MAX_CODE_BYTES)) begin
      eff_len = LEN_W'(MAX_CODE_BYTES);
    end else begin
      eff_len = code_length_r;
    end
    pos_inc   = LEN_W'(pos_r) + LEN_W'(1);
    last_byte = (pos_inc >= eff_len);
    pos_nxt   = last_byte ? '0 : pos_inc[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (acc_code) begin
      pos_r <= pos_nxt;
    end
  end

  // Lookup addresses
  logic [TABLE_AW-1:0] rd_addr_a, rd_addr_b;

  always_comb begin
    if (nibble_mode_r) begin
      rd_addr_a = TABLE_AW'({pos_r, 1'b0, in_code_byte[NIB_W-1:0]});
      rd_addr_b = TABLE_AW'({pos_r, 1'b1, in_code_byte[BYTE_W-1:NIB_W]});
    end else begin
      rd_addr_a = TABLE_AW'({pos_r, in_code_byte});
      rd_addr_b = rd_addr_a;
    end
  end

  // Table store: one write port, two registered read ports
  logic [TABLE_DW-1:0] table_mem [TABLE_DEPTH];
  logic [TABLE_DW-1:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (acc_write) begin
      table_mem[in_table_addr] <= in_table_word;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_a_r <= table_mem[rd_addr_a];
      rd_b_r <= table_mem[rd_addr_b];
    end
  end

  // Stage 1 control: lookup in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s1_nib_r   <= 1'b0;
    end else if (en) begin
      s1_valid_r <= acc_code;
      s1_last_r  <= last_byte;
      s1_nib_r   <= nibble_mode_r;
    end
  end

  // Stage 2: add the pair of looked-up words
  logic [PAIR_W-1:0] pair_r, pair_nxt;

  always_comb begin
    pair_nxt = {rd_a_r[TABLE_DW-1], rd_a_r};
    if (s1_nib_r) begin
      pair_nxt = pair_nxt + {rd_b_r[TABLE_DW-1], rd_b_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
      s2_last_r  <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_r <= pair_nxt;
    end
  end

  // Stage 3: accumulate, hand finished sums to the output register
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] out_data_r;

  assign sum_nxt = sum_r + {{(SUM_W-PAIR_W){pair_r[PAIR_W-1]}}, pair_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (en && s2_valid_r) begin
      sum_r <= s2_last_r ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && s2_valid_r && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid_r && s2_last_r) begin
      out_data_r <= sum_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

endmodule

`default_nettype wire

### rtl/core/clda_checker.sv
// ----------------------------------------------------------------------------
// clda_checker
// Port-level checks for the code lookup dot accumulator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module clda_checker
  import clda_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // Reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Input stalls only behind a waiting, untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("in_tready low without a blocked result");

  // A waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed or dropped while stalled");

  // A taken result never stalls the input: in_tready is high whenever
  // out_tready takes a waiting result
  a_no_stall_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |-> in_tready)
    else $error("input stalled while the result was taken");

endmodule

bind code_lut_dot_accumulate clda_checker u_clda_checker (.*);

`default_nettype wire

### sim/tb_code_lut_dot_accumulate.sv
// ----------------------------------------------------------------------------
// tb_code_lut_dot_accumulate
// Self-checking bench for the code lookup dot accumulator.
// ----------------------------------------------------------------------------
// A short table of directed words walks the value extremes, both word kinds,
// both lookup modes, the zero length and a length change in the middle of a
// code. Random phases follow. Each phase loads the unwritten entries that a
// code byte is about to read, mixes in stray writes, and runs under a new
// register setting. Every accepted word goes through a local scoring model
// whose sums queue up and are compared in order against the output stream.
// Both stream sides idle at random, except for one phase that runs steady.
// ----------------------------------------------------------------------------

module tb_code_lut_dot_accumulate;
  timeunit 1ns;
  timeprecision 1ps;

  import clda_pkg::*;

  localparam int ADDR_LSB = 0;
  localparam int WORD_LSB = ADDR_LSB + TABLE_AW;
  localparam int BYTE_LSB = WORD_LSB + TABLE_DW;
  localparam int PHASES   = 12;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_TBL,
    ROW_CODE
  } row_kind_t;

  // One directed row: register write, table write or code byte
  typedef struct packed {
    row_kind_t         kind;
    logic              typed;
    logic [31:0]       arg0;
    logic [31:0]       arg1;
    logic [SUM_W-1:0]  sum;
  } row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [13:0] table_addr, [45:14] table_word, [53:46] code_byte, [55:54] zero
  logic [IN_DATA_W-1:0]   in_tdata;
  // [0] cmd
  logic [IN_USER_W-1:0]   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [39:0] dot_sum
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_wr_en;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [CFG_DW-1:0]      cfg_wdata;

  // Scoring model state
  logic [TABLE_DW-1:0]    lut [TABLE_DEPTH];
  bit                     lut_loaded [TABLE_DEPTH];
  int unsigned            byte_pos;
  logic [SUM_W-1:0]       partial_sum;
  logic                   nib_mode;
  logic [LEN_W-1:0]       code_len;
  logic [SUM_W-1:0]       pending_sums [$];

  int unsigned            errors;
  bit                     steady;

  // Random phase plan: lookup mode, code length, words to send
  int unsigned phase_nib   [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
  int unsigned phase_len   [PHASES] = '{16, 64, 1, 3, 64, 0, 127, 100, 5, 1, 0, 0};
  int unsigned phase_words [PHASES] = '{120, 130, 90, 110, 160, 60, 130, 120,
                                        100, 60, 130, 120};

  code_lut_dot_accumulate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Table entry read by a byte at the current position (hi picks upper nibble)
  function automatic logic [TABLE_AW-1:0] lut_addr(input bit hi, input logic [7:0] b);
    if (nib_mode) begin
      return TABLE_AW'(byte_pos * 32 + (hi ? 16 + b[7:4] : b[3:0]));
    end
    return TABLE_AW'(byte_pos * 256 + b);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t row(input row_kind_t kind, input logic [31:0] a0,
                               input logic [31:0] a1, input logic typed,
                               input logic [SUM_W-1:0] sum);
    row_t r;
    r.kind  = kind;
    r.arg0  = a0;
    r.arg1  = a1;
    r.typed = typed;
    r.sum   = sum;
    return r;
  endfunction

  // Score one accepted word; queue the code sum when a code completes
  task automatic score_word(input cmd_t kind, input logic [IN_DATA_W-1:0] data,
                            input logic typed, input logic [SUM_W-1:0] typed_sum);
    logic [TABLE_AW-1:0] a;
    logic [BYTE_W-1:0]   b;
    logic [TABLE_DW-1:0] w;
    int unsigned         span;
    if (kind == CMD_TABLE_WRITE) begin
      a = data[ADDR_LSB +: TABLE_AW];
      lut[a] = data[WORD_LSB +: TABLE_DW];
      lut_loaded[a] = 1'b1;
    end else begin
      b = data[BYTE_LSB +: BYTE_W];
      w = lut[lut_addr(1'b0, b)];
      partial_sum = partial_sum + {{(SUM_W-TABLE_DW){w[TABLE_DW-1]}}, w};
      if (nib_mode) begin
        w = lut[lut_addr(1'b1, b)];
        partial_sum = partial_sum + {{(SUM_W-TABLE_DW){w[TABLE_DW-1]}}, w};
      end
      // zero length acts as one, oversize lengths clamp to the maximum
      span = (code_len == 0) ? 1 : ((code_len > MAX_CODE_BYTES) ? MAX_CODE_BYTES : code_len);
      if (byte_pos + 1 >= span) begin
        pending_sums.push_back(typed ? typed_sum : partial_sum);
        partial_sum = '0;
        byte_pos = 0;
      end else begin
        byte_pos = byte_pos + 1;
      end
    end
  endtask

  // Present one word and hold it until accepted, with random leading gaps
  task automatic push_word(input cmd_t kind, input logic [IN_DATA_W-1:0] data,
                           input logic typed, input logic [SUM_W-1:0] typed_sum);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    score_word(kind, data, typed, typed_sum);
  endtask

  task automatic send_entry(input logic [TABLE_AW-1:0] addr, input logic [TABLE_DW-1:0] word);
    push_word(CMD_TABLE_WRITE, {2'b00, 8'($urandom), word, addr}, 1'b0, '0);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input logic [SUM_W-1:0] typed_sum);
    push_word(CMD_CODE_BYTE, {2'b00, b, 32'($urandom), 14'($urandom)}, typed, typed_sum);
  endtask

  // Drop valid, drain all sums, let the pipeline empty, then write a register
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_NIBBLE_MODE: nib_mode = val[0];
      CFG_CODE_LENGTH: code_len = val;
      default: ;
    endcase
  endtask

  // Randomly stall the result side
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 15);
  end

  // Compare each accepted sum with the oldest expectation
  always @(posedge clk) begin : check_sums
    logic [SUM_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sum %h", out_tdata);
      end else begin
        want = pending_sums.pop_front();
        if (out_tdata !== want) begin
          errors++;
          if (errors <= 10) $display("sum mismatch: expected %h, got %h", want, out_tdata);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    row_t                directed_rows [$];
    row_t                r;
    logic [TABLE_AW-1:0] a;
    logic [BYTE_W-1:0]   b;
    int unsigned         sent;
    int unsigned         len;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_TABLE_WRITE;
    cfg_wr_en   = 1'b0;
    cfg_addr    = CFG_NIBBLE_MODE;
    cfg_wdata   = '0;
    errors      = 0;
    steady      = 1'b0;
    byte_pos    = 0;
    partial_sum = '0;
    nib_mode    = 1'b0;
    code_len    = CODE_LENGTH_RST;

    directed_rows = '{
      // reset length is 16: one byte alone gives no sum
      row(ROW_TBL,  32'h0000, 32'h7fff_ffff, 1'b0, '0),
      row(ROW_CODE, 32'h00,   '0,            1'b0, '0),
      row(ROW_REG,  CFG_NIBBLE_MODE, 32'd0,  1'b0, '0),
      row(ROW_REG,  CFG_CODE_LENGTH, 32'd2,  1'b0, '0),
      row(ROW_TBL,  32'h01ff, 32'h7fff_ffff, 1'b0, '0),
      row(ROW_CODE, 32'hff,   '0,            1'b1, 40'h00_ffff_fffe),
      // most negative entries
      row(ROW_TBL,  32'h0000, 32'h8000_0000, 1'b0, '0),
      row(ROW_TBL,  32'h0100, 32'h8000_0000, 1'b0, '0),
      row(ROW_CODE, 32'h00,   '0,            1'b0, '0),
      row(ROW_CODE, 32'h00,   '0,            1'b1, 40'hff_0000_0000),
      row(ROW_TBL,  32'h3fff, 32'h5555_5555, 1'b0, '0),
      // nibble lookups, single-byte codes
      row(ROW_REG,  CFG_NIBBLE_MODE, 32'd1,  1'b0, '0),
      row(ROW_REG,  CFG_CODE_LENGTH, 32'd1,  1'b0, '0),
      row(ROW_TBL,  32'h000f, 32'h0000_0001, 1'b0, '0),
      row(ROW_TBL,  32'h001f, 32'h0000_0002, 1'b0, '0),
      row(ROW_CODE, 32'hff,   '0,            1'b1, 40'h00_0000_0003),
      // zero length behaves as one
      row(ROW_REG,  CFG_CODE_LENGTH, 32'd0,  1'b0, '0),
      row(ROW_TBL,  32'h0010, 32'h0001_0000, 1'b0, '0),
      row(ROW_CODE, 32'h00,   '0,            1'b1, 40'hff_8001_0000),
      // shorten the length after two bytes: the next byte ends the code
      row(ROW_REG,  CFG_NIBBLE_MODE, 32'd0,  1'b0, '0),
      row(ROW_REG,  CFG_CODE_LENGTH, 32'd3,  1'b0, '0),
      row(ROW_TBL,  32'h0200, 32'h0000_0005, 1'b0, '0),
      row(ROW_CODE, 32'h00,   '0,            1'b0, '0),
      row(ROW_CODE, 32'h00,   '0,            1'b0, '0),
      row(ROW_REG,  CFG_CODE_LENGTH, 32'd2,  1'b0, '0),
      row(ROW_CODE, 32'h00,   '0,            1'b1, 40'hff_0000_0005)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      case (r.kind)
        ROW_REG:  write_reg(cfg_idx_t'(r.arg0[CFG_AW-1:0]), r.arg1[CFG_DW-1:0]);
        ROW_TBL:  send_entry(r.arg0[TABLE_AW-1:0], r.arg1);
        ROW_CODE: send_byte(r.arg0[BYTE_W-1:0], r.typed, r.sum);
        default: ;
      endcase
    end

    // Random phases
    for (int ph = 0; ph < PHASES; ph++) begin
      len = (ph >= 10) ? $urandom_range(1, MAX_CODE_BYTES) : phase_len[ph];
      write_reg(CFG_NIBBLE_MODE, CFG_DW'(phase_nib[ph]));
      write_reg(CFG_CODE_LENGTH, CFG_DW'(len));
      steady = (ph == 3);
      sent = 0;
      while (sent < phase_words[ph]) begin
        if ($urandom_range(99) < 20) begin
          // stray table write anywhere in the store
          send_entry(14'($urandom), rand_word());
          sent++;
        end else begin
          // load whatever this byte will read, then send the byte
          b = 8'($urandom);
          for (int h = 0; h < 2; h++) begin
            if (h == 0 || nib_mode) begin
              a = lut_addr(h[0], b);
              if (!lut_loaded[a]) begin
                send_entry(a, rand_word());
                sent++;
              end
            end
          end
          send_byte(b, 1'b0, '0);
          sent++;
        end
      end
    end
    steady = 1'b0;

    // Drain and let the pipeline settle
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### code_lut_dot_accumulate.f
rtl/core/clda_pkg.sv
rtl/core/code_lut_dot_accumulate.sv
rtl/core/clda_checker.sv
sim/tb_code_lut_dot_accumulate.sv
